// File: rtl/core/hps_pkg.sv
package hps_pkg;

    // Pipeline geometry.
    localparam int AddrBytes = 16;
    localparam int Ipv4Bytes = 4;
    localparam int MixCells  = AddrBytes + 2;
    localparam int ModBits   = 8;
    localparam int ModCells  = 64 / ModBits;
    localparam int Stages    = MixCells + ModCells;

    // FNV-1a 64-bit prime, 2^40 + 0x1B3; the start value is not the standard FNV-1a offset basis.
    localparam logic [63:0] FNV_OFFSET    = 64'd1469598103934665603;
    localparam logic [63:0] FNV_PRIME_LOW = 64'h0000_0000_0000_01B3;
    localparam int          FnvPrimeShift = 40;

    // Configuration register indexes.
    localparam logic [7:0] CFG_BASE_PORT     = 8'd0;
    localparam logic [7:0] CFG_CHANNEL_COUNT = 8'd1;
    localparam logic [7:0] CFG_IPV4_FAMILY   = 8'd2;
    localparam logic [7:0] CFG_IPV6_FAMILY   = 8'd3;

    typedef struct packed {
        logic [63:0]  hash;
        logic [127:0] addr;
        logic [15:0]  port;
        logic         is_ipv6;
    } hps_mix_t;

    typedef struct packed {
        logic [63:0] hash;
        logic [15:0] rem;
    } hps_mod_t;

    // One FNV-1a step: xor in the value, then multiply by the prime.
    function automatic logic [63:0] fnv_mix(input logic [63:0] h, input logic [15:0] v);
        logic [63:0] x;
        x = h ^ {48'd0, v};
        return (x << FnvPrimeShift) + (x * FNV_PRIME_LOW);
    endfunction

endpackage

// File: rtl/core/hps_if.sv
interface hps_in_if;
    import hps_pkg::*;
    logic        valid;
    logic        ready;
    logic        is_ipv6;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic [15:0] service_port;

    modport source (output valid, is_ipv6, addr_high, addr_low, service_port, input ready);
    modport sink   (input valid, is_ipv6, addr_high, addr_low, service_port, output ready);
endinterface

interface hps_out_if;
    import hps_pkg::*;
    logic        valid;
    logic        ready;
    logic [16:0] resolved_port;

    modport source (output valid, resolved_port, input ready);
    modport sink   (input valid, resolved_port, output ready);
endinterface

// File: rtl/core/hps_mix_cell.sv
module hps_mix_cell
    import hps_pkg::*;
(
    input  logic        clk,
    input  logic        load,
    input  logic        active,
    input  logic [15:0] value,
    input  hps_mix_t    d,
    output hps_mix_t    q
);

    hps_mix_t q_reg;
    hps_mix_t q_next;

    // The address moves up one byte per cell so the next byte is always on top.
    always_comb
    begin
        q_next      = d;
        q_next.addr = d.addr << 8;
        if (active)
        begin
            q_next.hash = fnv_mix(d.hash, value);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

// File: rtl/core/hps_mod_cell.sv
module hps_mod_cell
    import hps_pkg::*;
(
    input  logic        clk,
    input  logic        load,
    input  logic [15:0] divisor,
    input  hps_mod_t    d,
    output hps_mod_t    q
);

    hps_mod_t q_reg;
    hps_mod_t q_next;

    // Restoring long division, ModBits (eight) dividend bits per cell.
    always_comb
    begin
        logic [16:0] t;
        logic [63:0] h;
        logic [15:0] r;
        h = d.hash;
        r = d.rem;
        for (int i = 0; i < ModBits; i++)
        begin
            t = {r, h[63]};
            h = h << 1;
            if (t >= {1'b0, divisor})
            begin
                t = t - {1'b0, divisor};
            end
            r = t[15:0];
        end
        q_next.hash = h;
        q_next.rem  = r;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

// File: rtl/core/hashed_port_select_unit.sv
// Channel   Direction  Contents
// in_ch     sink       is_ipv6, addr_high, addr_low, service_port
// out_ch    source     resolved_port
// cfg_*     write      cfg_we, cfg_index, cfg_wdata (base, count, family codes)
//
// One transfer is accepted per cycle unless the pipe stalls; each item passes through
// 18 hash cells (at most one FNV-1a step each), 8 division cells (8 dividend bits
// each) and the output register.
// Reset clears the valid bits and loads the configuration reset values.
// Stalls collapse bubbles: a cell loads whenever it is empty or the cell after it loads.
module hashed_port_select_unit
    import hps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    hps_in_if.sink      in_ch,
    hps_out_if.source   out_ch,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    // Configuration registers.
    logic [15:0] base_port_reg;
    logic [15:0] channel_count_reg;
    logic [7:0]  ipv4_family_reg;
    logic [7:0]  ipv6_family_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_port_reg     <= 16'd0;
            channel_count_reg <= 16'd1;
            ipv4_family_reg   <= 8'd2;
            ipv6_family_reg   <= 8'd10;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BASE_PORT:     base_port_reg     <= cfg_wdata;
                CFG_CHANNEL_COUNT: channel_count_reg <= cfg_wdata;
                CFG_IPV4_FAMILY:   ipv4_family_reg   <= cfg_wdata[7:0];
                CFG_IPV6_FAMILY:   ipv6_family_reg   <= cfg_wdata[7:0];
                default:           ;
            endcase
        end
    end

    // A channel count of zero behaves as one.
    logic [15:0] divisor;
    assign divisor = (channel_count_reg == 16'd0) ? 16'd1 : channel_count_reg;

    // Valid bits and load enables along the chain. Cell k loads when it is
    // empty or when its contents move on in the same cycle.
    logic [Stages-1:0] v_reg;
    logic [Stages-1:0] v_next;
    logic [Stages:0]   load;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [16:0]       resolved_port_reg;

    always_comb
    begin
        load[Stages] = !out_valid_reg || out_ch.ready;
        for (int k = Stages - 1; k >= 0; k--)
        begin
            load[k] = !v_reg[k] || load[k + 1];
        end
        v_next[0] = load[0] ? in_ch.valid : v_reg[0];
        for (int k = 1; k < Stages; k++)
        begin
            if (load[k])
            begin
                v_next[k] = v_reg[k - 1];
            end
            else
            begin
                v_next[k] = v_reg[k];
            end
        end
        out_valid_next = load[Stages] ? v_reg[Stages-1] : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v_reg         <= v_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ch.ready = load[0];

    // Hash cells: the address bytes, then the family code, then the port.
    hps_mix_t mix_d [MixCells];
    hps_mix_t mix_q [MixCells];

    assign mix_d[0] = '{hash: FNV_OFFSET, addr: {in_ch.addr_high, in_ch.addr_low},
                        port: in_ch.service_port, is_ipv6: in_ch.is_ipv6};

    for (genvar k = 0; k < MixCells; k++)
    begin : g_mix
        logic        active;
        logic [15:0] value;

        if (k > 0)
        begin : g_link
            assign mix_d[k] = mix_q[k - 1];
        end

        if (k < AddrBytes)
        begin : g_byte
            // Bytes past the fourth only count for IPv6.
            assign active = (k < Ipv4Bytes) || mix_d[k].is_ipv6;
            assign value  = {8'd0, mix_d[k].addr[127:120]};
        end
        else if (k == AddrBytes)
        begin : g_family
            assign active = 1'b1;
            assign value  = {8'd0, mix_d[k].is_ipv6 ? ipv6_family_reg : ipv4_family_reg};
        end
        else
        begin : g_port
            assign active = 1'b1;
            assign value  = mix_d[k].port;
        end

        hps_mix_cell u_cell
        (
            .clk    (clk),
            .load   (load[k]),
            .active (active),
            .value  (value),
            .d      (mix_d[k]),
            .q      (mix_q[k])
        );
    end

    // Division cells: the remainder of the hash by the channel count.
    hps_mod_t mod_d [ModCells];
    hps_mod_t mod_q [ModCells];

    assign mod_d[0] = '{hash: mix_q[MixCells-1].hash, rem: 16'd0};

    for (genvar k = 0; k < ModCells; k++)
    begin : g_mod
        if (k > 0)
        begin : g_link
            assign mod_d[k] = mod_q[k - 1];
        end

        hps_mod_cell u_cell
        (
            .clk     (clk),
            .load    (load[MixCells + k]),
            .divisor (divisor),
            .d       (mod_d[k]),
            .q       (mod_q[k])
        );
    end

    // Output register: the base port plus the remainder.
    always_ff @(posedge clk)
    begin
        if (load[Stages])
        begin
            resolved_port_reg <= {1'b0, base_port_reg} + {1'b0, mod_q[ModCells-1].rem};
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.resolved_port = resolved_port_reg;

`ifndef SYNTH
    // An accepted transfer always lands in the first hash cell.
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |=> v_reg[0])
        else $error("accepted item did not enter the first cell");

    // The remainder leaving the last division cell is below the divisor.
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[Stages-1] |-> (mod_q[ModCells-1].rem < divisor))
        else $error("remainder not below the channel count");

    // A finished item moves into an empty output register.
    a_out_fill: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[Stages-1] && !out_valid_reg |=> out_valid_reg)
        else $error("result lost before the output register");
`endif

endmodule

// File: tb/tb_top.sv
module tb_top;
    import hps_pkg::*;

    // PipeDepth is the number of pipe stages; the final wait allows a little more.
    localparam int PipeDepth   = 27;
    localparam int IdleLimit   = 4000;
    localparam int RandomItems = 1850;

    typedef struct packed {
        logic        is_ipv6;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
        logic [15:0] service_port;
    } service_t;

    // One row of the directed table. A known port of -1 means the row is
    // checked against the predictor alone.
    typedef struct {
        service_t svc;
        int       known_port;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic        cfg_we;
    logic [7:0]  cfg_index;
    logic [15:0] cfg_wdata;

    hps_in_if  in_ch ();
    hps_out_if out_ch ();

    hashed_port_select_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Shadow copy of the configuration registers, kept by the predictor.
    logic [15:0] base_port_q;
    logic [15:0] channel_count_q;
    logic [7:0]  ipv4_code_q;
    logic [7:0]  ipv6_code_q;

    logic [16:0] port_queue[$];
    int          fail_count;
    int          idle_cycles;
    int          send_idle_pct;
    int          recv_stall_pct;
    bit          hold_off;

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // One FNV-1a step, written out with a plain 64-bit multiply.
    function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [63:0] v);
        logic [63:0] prime;
        prime = 64'd1099511628211;
        return (h ^ v) * prime;
    endfunction

    function automatic logic [16:0] resolve_port(input service_t s);
        logic [63:0]  h;
        logic [127:0] bytes;
        logic [63:0]  divisor;
        int           n;
        h = 64'd1469598103934665603;
        bytes = {s.addr_high, s.addr_low};
        n = s.is_ipv6 ? 16 : 4;
        for (int i = 0; i < n; i++)
        begin
            h = fnv_step(h, {56'd0, bytes[127 - 8 * i -: 8]});
        end
        h = fnv_step(h, {56'd0, s.is_ipv6 ? ipv6_code_q : ipv4_code_q});
        h = fnv_step(h, {48'd0, s.service_port});
        // A channel count of zero behaves as a count of one.
        divisor = (channel_count_q == 16'd0) ? 64'd1 : {48'd0, channel_count_q};
        return 17'({1'b0, base_port_q} + 17'(h % divisor));
    endfunction

    function automatic service_t random_service();
        service_t s;
        s.is_ipv6      = 1'($urandom);
        s.addr_high    = {$urandom, $urandom};
        s.addr_low     = {$urandom, $urandom};
        s.service_port = 16'($urandom);
        case ($urandom_range(0, 7))
            0: s.service_port = 16'hFFFF;
            1: s.service_port = 16'd0;
            2: s.addr_high = '1;
            default: ;
        endcase
        return s;
    endfunction

    // Configuration writes happen only while the pipe is empty.
    task automatic write_reg(input logic [7:0] idx, input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_BASE_PORT:     base_port_q     = value;
            CFG_CHANNEL_COUNT: channel_count_q = value;
            CFG_IPV4_FAMILY:   ipv4_code_q     = value[7:0];
            CFG_IPV6_FAMILY:   ipv6_code_q     = value[7:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Offers one item and holds it until the transfer has taken place.
    // Valid stays high afterwards so that the next item can follow at once.
    task automatic send_service(input service_t s);
        while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.is_ipv6      <= s.is_ipv6;
        in_ch.addr_high    <= s.addr_high;
        in_ch.addr_low     <= s.addr_low;
        in_ch.service_port <= s.service_port;
        port_queue.push_back(resolve_port(s));
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic drain_pipe();
        in_ch.valid <= 1'b0;
        while (port_queue.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // Receiver: stalls at random, or for a long stretch while hold_off is set.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else
        begin
            out_ch.ready <= !hold_off &&
                !(recv_stall_pct > 0 && $urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Compares each transfer out with the oldest expected port.
    always @(posedge clk)
    begin
        logic [16:0] want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (port_queue.size() == 0)
            begin
                $error("resolved_port: unexpected transfer, actual %0d",
                       out_ch.resolved_port);
                fail_count++;
            end
            else
            begin
                want = port_queue.pop_front();
                if (out_ch.resolved_port !== want)
                begin
                    $error("resolved_port: expected %0d, actual %0d",
                           want, out_ch.resolved_port);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: counts cycles in which neither side moves a transfer.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IdleLimit)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        stim_row_t rows[$];
        stim_row_t row;
        int        pct_set[4][2];

        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_wdata       = '0;
        in_ch.valid        = 1'b0;
        in_ch.is_ipv6      = 1'b0;
        in_ch.addr_high    = '0;
        in_ch.addr_low     = '0;
        in_ch.service_port = '0;
        base_port_q     = 16'd0;
        channel_count_q = 16'd1;
        ipv4_code_q     = 8'd2;
        ipv6_code_q     = 8'd10;
        fail_count      = 0;
        idle_cycles     = 0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_off        = 1'b0;
        pct_set = '{'{0, 0}, '{86, 0}, '{0, 86}, '{13, 13}};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, reset configuration: a count of one always gives base 0.
        rows.push_back('{'{1'b0, 64'd0, 64'd0, 16'd0}, 0});
        rows.push_back('{'{1'b1, '1, '1, 16'hFFFF}, 0});
        rows.push_back('{'{1'b0, 64'hE000_0001_FFFF_FFFF, '1, 16'd5000}, 0});
        foreach (rows[i])
        begin
            row = rows[i];
            if (row.known_port >= 0 && resolve_port(row.svc) != 17'(row.known_port))
            begin
                $error("resolved_port: table row %0d expected %0d, predictor %0d",
                       i, row.known_port, resolve_port(row.svc));
                fail_count++;
            end
            send_service(row.svc);
        end
        drain_pipe();

        // Extremes of the registers; then IPv4 unused bits must not matter.
        write_reg(CFG_BASE_PORT, 16'hFFFF);
        write_reg(CFG_CHANNEL_COUNT, 16'hFFFF);
        write_reg(CFG_IPV4_FAMILY, 16'h00FF);
        write_reg(CFG_IPV6_FAMILY, 16'h0000);
        write_reg(8'd7, 16'h1234);
        send_service('{1'b0, 64'hEFFF_FFFF_0000_0000, 64'd0, 16'hFFFF});
        send_service('{1'b0, 64'hEFFF_FFFF_FFFF_FFFF, '1, 16'hFFFF});
        send_service('{1'b1, 64'hFF02_0000_0000_0000, 64'd1, 16'd0});
        send_service('{1'b1, 64'd0, 64'd0, 16'd1});
        drain_pipe();
        // A channel count of zero acts as one, so the base port comes back.
        write_reg(CFG_CHANNEL_COUNT, 16'd0);
        send_service('{1'b1, '1, 64'd0, 16'd80});
        send_service('{1'b0, 64'h0102_0304_0000_0000, 64'd0, 16'd80});
        drain_pipe();

        // Random part, in phases with fresh settings and idling patterns.
        for (int ph = 0; ph < 8; ph++)
        begin
            write_reg(CFG_BASE_PORT, (ph == 1) ? 16'd0 : 16'($urandom));
            write_reg(CFG_CHANNEL_COUNT,
                      (ph == 2) ? 16'hFFFF : 16'($urandom_range(1, (ph % 2) ? 16 : 65535)));
            write_reg(CFG_IPV4_FAMILY, 16'($urandom_range(0, 255)));
            write_reg(CFG_IPV6_FAMILY, 16'($urandom_range(0, 255)));
            send_idle_pct  = pct_set[ph % 4][0];
            recv_stall_pct = pct_set[ph % 4][1];
            if (ph == 4)
            begin
                // Long receiver hold-off while items keep arriving.
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (200) @(posedge clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            for (int k = 0; k < RandomItems / 8; k++)
            begin
                send_service(random_service());
                if (k == 100)
                begin
                    // Sender pauses until every expected port has come back.
                    in_ch.valid <= 1'b0;
                    while (port_queue.size() != 0)
                    begin
                        @(posedge clk);
                    end
                end
            end
            drain_pipe();
        end

        repeat (PipeDepth + 8) @(posedge clk);
        if (fail_count == 0 && port_queue.size() == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
